FILE: design/mchp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mchp_pkg;

    // section tags
    localparam logic [4:0] SEC_NAME_LEN   = 5'd0;
    localparam logic [4:0] SEC_NAME       = 5'd1;
    localparam logic [4:0] SEC_LEVEL      = 5'd2;
    localparam logic [4:0] SEC_FLAGS      = 5'd3;
    localparam logic [4:0] SEC_KEEPALIVE  = 5'd4;
    localparam logic [4:0] SEC_PROPS_LEN  = 5'd5;
    localparam logic [4:0] SEC_PROPS      = 5'd6;
    localparam logic [4:0] SEC_ID_LEN     = 5'd7;
    localparam logic [4:0] SEC_ID         = 5'd8;
    localparam logic [4:0] SEC_WPROPS_LEN = 5'd9;
    localparam logic [4:0] SEC_WPROPS     = 5'd10;
    localparam logic [4:0] SEC_TOPIC_LEN  = 5'd11;
    localparam logic [4:0] SEC_TOPIC      = 5'd12;
    localparam logic [4:0] SEC_MSG_LEN    = 5'd13;
    localparam logic [4:0] SEC_MSG        = 5'd14;
    localparam logic [4:0] SEC_USER_LEN   = 5'd15;
    localparam logic [4:0] SEC_USER       = 5'd16;
    localparam logic [4:0] SEC_PASS_LEN   = 5'd17;
    localparam logic [4:0] SEC_PASS       = 5'd18;
    localparam logic [4:0] SEC_END        = 5'd19;

    localparam logic [6:0] LEVEL_V5 = 7'd5;

    // connect flag bits
    localparam int FLAG_WILL     = 2;
    localparam int FLAG_PASSWORD = 6;
    localparam int FLAG_USERNAME = 7;

    // status bits
    localparam int ST_PROPS    = 0;
    localparam int ST_WPROPS   = 1;
    localparam int ST_EMPTY_ID = 2;

    typedef struct packed {
        logic [4:0]  section;
        logic [7:0]  byte_out;
        logic        done_res;
        logic        error;
        logic [6:0]  protocol_level;
        logic        reflect;
        logic [7:0]  connect_flags;
        logic [15:0] keep_alive;
        logic        has_properties;
        logic        has_will_properties;
        logic        empty_client_id;
    } t_mchp_result;

endpackage

`default_nettype wire

FILE: design/mqtt_connect_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// MQTT CONNECT body tagger.
// Input channel: i_valid / o_stall carry one body byte (i_data_byte) per transfer,
// i_first_byte marks the first byte of a new packet and restarts parsing.
// Output channel: o_valid / i_stall carry one tagged result per input byte: the
// section of the byte, the byte itself, done and error flags and the header
// fields decoded so far (level, reflect, flags, keep-alive, status flags).
// Each result is registered in the output register, or in the skid register.
// Throughput is one byte per cycle while o_stall is low: the parse state is updated by a single
// pass of logic between the state registers and the result register.
// When the receiver stalls, a second result is caught in a skid register and
// o_stall rises the cycle after; it falls once the skid entry has moved on.
// Synchronous reset (i_rst_n low) empties both result registers and returns
// the parser to the start of a packet with reflect set and all fields zero.
module mqtt_connect_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_section,
    output logic [7:0]       o_byte_out,
    output logic             o_done_res,
    output logic             o_error,
    output logic [6:0]       o_protocol_level,
    output logic             o_reflect,
    output logic [7:0]       o_connect_flags,
    output logic [15:0]      o_keep_alive,
    output logic             o_has_properties,
    output logic             o_has_will_properties,
    output logic             o_empty_client_id
);

    mchp_pkg::t_mchp_result step_res;
    mchp_pkg::t_mchp_result r_out;
    mchp_pkg::t_mchp_result r_skid;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic                   take;
    logic                   out_taken;
    logic                   load_out_new;
    logic                   load_out_skid;
    logic                   load_skid;

    assign take          = i_valid && !r_skid_valid;
    assign out_taken     = r_out_valid && !i_stall;
    assign load_out_new  = take && (!r_out_valid || out_taken);
    assign load_skid     = take && r_out_valid && !out_taken;
    assign load_out_skid = !take && r_skid_valid && out_taken;

    mchp_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (load_out_new || load_out_skid)
                r_out_valid <= 1'b1;
            else if (out_taken)
                r_out_valid <= 1'b0;

            if (load_skid)
                r_skid_valid <= 1'b1;
            else if (load_out_skid)
                r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_new)
            r_out <= step_res;
        else if (load_out_skid)
            r_out <= r_skid;
        if (load_skid)
            r_skid <= step_res;
    end

    assign o_stall               = r_skid_valid;
    assign o_valid               = r_out_valid;
    assign o_section             = r_out.section;
    assign o_byte_out            = r_out.byte_out;
    assign o_done_res            = r_out.done_res;
    assign o_error               = r_out.error;
    assign o_protocol_level      = r_out.protocol_level;
    assign o_reflect             = r_out.reflect;
    assign o_connect_flags       = r_out.connect_flags;
    assign o_keep_alive          = r_out.keep_alive;
    assign o_has_properties      = r_out.has_properties;
    assign o_has_will_properties = r_out.has_will_properties;
    assign o_empty_client_id     = r_out.empty_client_id;

endmodule

`default_nettype wire

FILE: design/mchp_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module mchp_decode (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_first_byte,
    output mchp_pkg::t_mchp_result     o_result
);

    logic [4:0]  r_sec,    n_sec;
    logic [15:0] r_fc,     n_fc;
    logic [27:0] r_rem,    n_rem;
    logic [1:0]  r_vbi,    n_vbi;
    logic [6:0]  r_level,  n_level;
    logic        r_reflect, n_reflect;
    logic [7:0]  r_flags,  n_flags;
    logic [15:0] r_keep,   n_keep;
    logic [2:0]  r_status, n_status;

    logic [4:0]  c_sec;
    logic [15:0] c_fc;
    logic [27:0] c_rem;
    logic [1:0]  c_vbi;
    logic [6:0]  c_level;
    logic        c_reflect;
    logic [7:0]  c_flags;
    logic [15:0] c_keep;
    logic [2:0]  c_status;

    logic        do_enter;
    logic [4:0]  enter_req;
    logic [4:0]  enter_sec;
    logic        done;
    logic        err;
    logic [15:0] len;
    logic [15:0] fc_dec;
    logic [27:0] props_add;

    // skip optional sections whose conditions are not met
    function automatic logic [4:0] next_needed(input logic [4:0] s, input logic [6:0] lvl,
                                               input logic [7:0] flg);
        logic [4:0] t;
        logic       v5;
        logic       will;
        v5   = (lvl == mchp_pkg::LEVEL_V5);
        will = flg[mchp_pkg::FLAG_WILL];
        t    = s;
        if (t == mchp_pkg::SEC_PROPS_LEN && !v5) t = mchp_pkg::SEC_ID_LEN;
        if (t == mchp_pkg::SEC_WPROPS_LEN && !(will && v5)) t = mchp_pkg::SEC_TOPIC_LEN;
        if (t == mchp_pkg::SEC_TOPIC_LEN && !will) t = mchp_pkg::SEC_MSG_LEN;
        if (t == mchp_pkg::SEC_MSG_LEN && !will) t = mchp_pkg::SEC_USER_LEN;
        if (t == mchp_pkg::SEC_USER_LEN && !flg[mchp_pkg::FLAG_USERNAME])
            t = mchp_pkg::SEC_PASS_LEN;
        if (t == mchp_pkg::SEC_PASS_LEN && !flg[mchp_pkg::FLAG_PASSWORD])
            t = mchp_pkg::SEC_END;
        if (t > mchp_pkg::SEC_END) t = mchp_pkg::SEC_END;
        return t;
    endfunction

    always_comb begin
        // a first byte restarts from the reset state before it is parsed
        if (i_first_byte) begin
            c_sec     = mchp_pkg::SEC_NAME_LEN;
            c_fc      = '0;
            c_rem     = '0;
            c_vbi     = '0;
            c_level   = '0;
            c_reflect = 1'b1;
            c_flags   = '0;
            c_keep    = '0;
            c_status  = '0;
        end else begin
            c_sec     = r_sec;
            c_fc      = r_fc;
            c_rem     = r_rem;
            c_vbi     = r_vbi;
            c_level   = r_level;
            c_reflect = r_reflect;
            c_flags   = r_flags;
            c_keep    = r_keep;
            c_status  = r_status;
        end
    end

    always_comb begin
        case (c_vbi)
            2'd0:    props_add = {21'b0, i_data_byte[6:0]};
            2'd1:    props_add = {14'b0, i_data_byte[6:0], 7'b0};
            2'd2:    props_add = {7'b0, i_data_byte[6:0], 14'b0};
            default: props_add = {i_data_byte[6:0], 21'b0};
        endcase
    end

    assign len    = c_fc | {8'b0, i_data_byte};
    assign fc_dec = c_fc - 16'd1;

    always_comb begin
        n_sec     = c_sec;
        n_fc      = c_fc;
        n_rem     = c_rem;
        n_vbi     = c_vbi;
        n_level   = c_level;
        n_reflect = c_reflect;
        n_flags   = c_flags;
        n_keep    = c_keep;
        n_status  = c_status;
        do_enter  = 1'b0;
        enter_req = c_sec;
        err       = 1'b0;
        enter_sec = c_sec;
        done      = 1'b0;

        case (c_sec)
            mchp_pkg::SEC_NAME_LEN, mchp_pkg::SEC_ID_LEN, mchp_pkg::SEC_TOPIC_LEN,
            mchp_pkg::SEC_MSG_LEN, mchp_pkg::SEC_USER_LEN, mchp_pkg::SEC_PASS_LEN: begin
                if (c_vbi == 2'd0) begin
                    n_fc  = {i_data_byte, 8'b0};
                    n_vbi = 2'd1;
                end else begin
                    if (c_sec == mchp_pkg::SEC_ID_LEN && len == 16'd0)
                        n_status[mchp_pkg::ST_EMPTY_ID] = 1'b1;
                    if (len == 16'd0) begin
                        do_enter  = 1'b1;
                        enter_req = c_sec + 5'd2;
                    end else begin
                        n_sec = c_sec + 5'd1;
                        n_fc  = len;
                        n_vbi = 2'd0;
                    end
                end
            end
            mchp_pkg::SEC_NAME, mchp_pkg::SEC_ID, mchp_pkg::SEC_TOPIC,
            mchp_pkg::SEC_MSG, mchp_pkg::SEC_USER, mchp_pkg::SEC_PASS: begin
                n_fc = fc_dec;
                if (fc_dec == 16'd0) begin
                    do_enter  = 1'b1;
                    enter_req = c_sec + 5'd1;
                end
            end
            mchp_pkg::SEC_LEVEL: begin
                n_reflect = ~i_data_byte[7];
                n_level   = i_data_byte[6:0];
                do_enter  = 1'b1;
                enter_req = mchp_pkg::SEC_FLAGS;
            end
            mchp_pkg::SEC_FLAGS: begin
                n_flags   = i_data_byte;
                do_enter  = 1'b1;
                enter_req = mchp_pkg::SEC_KEEPALIVE;
            end
            mchp_pkg::SEC_KEEPALIVE: begin
                if (c_vbi == 2'd0) begin
                    n_keep = {i_data_byte, 8'b0};
                    n_vbi  = 2'd1;
                end else begin
                    n_keep    = c_keep | {8'b0, i_data_byte};
                    do_enter  = 1'b1;
                    enter_req = mchp_pkg::SEC_PROPS_LEN;
                end
            end
            mchp_pkg::SEC_PROPS_LEN, mchp_pkg::SEC_WPROPS_LEN: begin
                n_rem = c_rem | props_add;
                if (i_data_byte[7]) begin
                    // continuation on the fourth length byte is malformed
                    if (c_vbi == 2'd3) begin
                        err   = 1'b1;
                        n_sec = mchp_pkg::SEC_END;
                        n_vbi = 2'd0;
                    end else begin
                        n_vbi = c_vbi + 2'd1;
                    end
                end else if (n_rem != 28'd0) begin
                    if (c_sec == mchp_pkg::SEC_PROPS_LEN)
                        n_status[mchp_pkg::ST_PROPS] = 1'b1;
                    else
                        n_status[mchp_pkg::ST_WPROPS] = 1'b1;
                    n_sec = c_sec + 5'd1;
                    n_vbi = 2'd0;
                end else begin
                    do_enter  = 1'b1;
                    enter_req = c_sec + 5'd2;
                end
            end
            mchp_pkg::SEC_PROPS, mchp_pkg::SEC_WPROPS: begin
                n_rem = c_rem - 28'd1;
                if (n_rem == 28'd0) begin
                    do_enter  = 1'b1;
                    enter_req = c_sec + 5'd1;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (do_enter) begin
            enter_sec = next_needed(enter_req, n_level, n_flags);
            n_sec     = enter_sec;
            n_vbi     = 2'd0;
            n_fc      = 16'd0;
            if (enter_sec == mchp_pkg::SEC_PROPS_LEN || enter_sec == mchp_pkg::SEC_WPROPS_LEN)
                n_rem = 28'd0;
            if (enter_sec == mchp_pkg::SEC_END)
                done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec     <= mchp_pkg::SEC_NAME_LEN;
            r_fc      <= '0;
            r_rem     <= '0;
            r_vbi     <= '0;
            r_level   <= '0;
            r_reflect <= 1'b1;
            r_flags   <= '0;
            r_keep    <= '0;
            r_status  <= '0;
        end else if (i_take) begin
            r_sec     <= n_sec;
            r_fc      <= n_fc;
            r_rem     <= n_rem;
            r_vbi     <= n_vbi;
            r_level   <= n_level;
            r_reflect <= n_reflect;
            r_flags   <= n_flags;
            r_keep    <= n_keep;
            r_status  <= n_status;
        end
    end

    always_comb begin
        o_result.section             = c_sec;
        o_result.byte_out            = i_data_byte;
        o_result.done_res            = done;
        o_result.error               = err;
        o_result.protocol_level      = n_level;
        o_result.reflect             = n_reflect;
        o_result.connect_flags       = n_flags;
        o_result.keep_alive          = n_keep;
        o_result.has_properties      = n_status[mchp_pkg::ST_PROPS];
        o_result.has_will_properties = n_status[mchp_pkg::ST_WPROPS];
        o_result.empty_client_id     = n_status[mchp_pkg::ST_EMPTY_ID];
    end

endmodule

`default_nettype wire
